/* hdl/led_vu_pkg.sv */
// ----------------------------------------------------------------------------
// led_vu_pkg
// Shared widths, register map, constants and control types of the VU meter.
// ----------------------------------------------------------------------------
`default_nettype none

package led_vu_pkg;

	localparam int AMP_W     = 16;
	localparam int DB_W      = 24;
	localparam int COEF_W    = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 3;
	localparam int LG_W      = 20;
	localparam int LED_W     = 6;
	localparam int IDX_W     = 8;
	localparam int HUE_W     = 8;
	localparam int BRI_W     = 8;
	localparam int ZONE_W    = 7;

	localparam int LED_COUNT_DEF       = 60;
	localparam int FULL_BRIGHTNESS_DEF = 255;
	localparam int DIM_BRIGHTNESS_DEF  = 8;
	localparam int FLIP_ORDER_DEF      = 0;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DB       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEDS_PER_DB  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORANGE_INDEX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RED_INDEX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_RISE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FALL   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_RISE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_FALL    = 3'd7;

	localparam logic [15:0]       RST_MIN_DB       = 16'd0;
	localparam logic [15:0]       RST_LEDS_PER_DB  = 16'd256;
	localparam logic [ZONE_W-1:0] RST_ORANGE_INDEX = 7'd40;
	localparam logic [ZONE_W-1:0] RST_RED_INDEX    = 7'd50;
	localparam logic [COEF_W-1:0] RST_LEVEL_RISE   = 17'd13107;
	localparam logic [COEF_W-1:0] RST_LEVEL_FALL   = 17'd3277;
	localparam logic [COEF_W-1:0] RST_PEAK_RISE    = 17'd65536;
	localparam logic [COEF_W-1:0] RST_PEAK_FALL    = 17'd66;

	// 115.82 in Q8.16, 9.1024*ln2 in Q3.16
	localparam logic [DB_W-1:0]   DB_OFFSET = 24'd7590380;
	localparam logic [18:0]       DB_SLOPE  = 19'd413487;
	localparam logic [COEF_W-1:0] COEF_ONE  = 17'd65536;

	localparam logic [HUE_W-1:0] HUE_GREEN  = 8'd96;
	localparam logic [HUE_W-1:0] HUE_ORANGE = 8'd32;
	localparam logic [HUE_W-1:0] HUE_RED    = 8'd0;

	localparam logic signed [IDX_W-1:0] LED_IDX_MAX  = 8'sd64;
	localparam logic signed [IDX_W-1:0] LED_IDX_NEG  = -8'sd1;
	localparam logic signed [IDX_W-1:0] LED_IDX_ZERO = 8'sd0;

	typedef struct packed {
		logic load_amp;
		logic do_log;
		logic do_lerp;
		logic do_db;
		logic do_trk;
		logic do_upd;
		logic do_map;
		logic do_sat;
		logic step_led;
	} led_vu_cmd_t;

	typedef struct packed {
		logic led_last;
	} led_vu_sts_t;

	// log2(1+i/16) in Q1.16, rounded
	function automatic logic [16:0] log_frac(input logic [4:0] i);
		logic [16:0] v;
		case (i)
			5'd0: v = 17'd0;
			5'd1: v = 17'd5732;
			5'd2: v = 17'd11136;
			5'd3: v = 17'd16248;
			5'd4: v = 17'd21098;
			5'd5: v = 17'd25711;
			5'd6: v = 17'd30109;
			5'd7: v = 17'd34312;
			5'd8: v = 17'd38336;
			5'd9: v = 17'd42196;
			5'd10: v = 17'd45904;
			5'd11: v = 17'd49472;
			5'd12: v = 17'd52911;
			5'd13: v = 17'd56229;
			5'd14: v = 17'd59434;
			5'd15: v = 17'd62534;
			5'd16: v = 17'd65536;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* hdl/led_vu_amp_if.sv */
// ----------------------------------------------------------------------------
// led_vu_amp_if
// Amplitude channel: valid/ready handshake with one 16-bit amplitude.
// ----------------------------------------------------------------------------
`default_nettype none

interface led_vu_amp_if;
	logic                            valid;
	logic                            ready;
	logic [led_vu_pkg::AMP_W-1:0]    amplitude;

	modport source (output valid, output amplitude, input ready);
	modport sink   (input valid, input amplitude, output ready);
endinterface

`default_nettype wire

/* hdl/led_vu_led_if.sv */
// ----------------------------------------------------------------------------
// led_vu_led_if
// LED channel: valid/ready handshake with one LED record per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface led_vu_led_if;
	logic                                  valid;
	logic                                  ready;
	logic [led_vu_pkg::LED_W-1:0]          led_position;
	logic [led_vu_pkg::HUE_W-1:0]          hue;
	logic [led_vu_pkg::BRI_W-1:0]          brightness;
	logic signed [led_vu_pkg::IDX_W-1:0]   level_led;
	logic signed [led_vu_pkg::IDX_W-1:0]   peak_led;
	logic                                  last_led;

	modport source (output valid, output led_position, output hue, output brightness,
		output level_led, output peak_led, output last_led, input ready);
	modport sink   (input valid, input led_position, input hue, input brightness,
		input level_led, input peak_led, input last_led, output ready);
endinterface

`default_nettype wire

/* hdl/led_vu_ctrl.sv */
// ----------------------------------------------------------------------------
// led_vu_ctrl
// Sequencer: walks one amplitude through the datapath steps, then the LEDs.
// ----------------------------------------------------------------------------
`default_nettype none

module led_vu_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     amp_valid,
	output logic                          amp_ready,
	output logic                          leds_valid,
	input  wire logic                     leds_ready,
	input  wire led_vu_pkg::led_vu_sts_t  sts,
	output led_vu_pkg::led_vu_cmd_t       cmd
);
	import led_vu_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOG  = 4'd1;
	localparam logic [3:0] ST_LERP = 4'd2;
	localparam logic [3:0] ST_DB   = 4'd3;
	localparam logic [3:0] ST_TRK  = 4'd4;
	localparam logic [3:0] ST_UPD  = 4'd5;
	localparam logic [3:0] ST_MAP  = 4'd6;
	localparam logic [3:0] ST_SAT  = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load_amp = amp_valid;
				if (amp_valid) state_nxt = ST_LOG;
			end
			ST_LOG: begin
				cmd.do_log = 1'b1;
				state_nxt  = ST_LERP;
			end
			ST_LERP: begin
				cmd.do_lerp = 1'b1;
				state_nxt   = ST_DB;
			end
			ST_DB: begin
				cmd.do_db = 1'b1;
				state_nxt = ST_TRK;
			end
			ST_TRK: begin
				cmd.do_trk = 1'b1;
				state_nxt  = ST_UPD;
			end
			ST_UPD: begin
				cmd.do_upd = 1'b1;
				state_nxt  = ST_MAP;
			end
			ST_MAP: begin
				cmd.do_map = 1'b1;
				state_nxt  = ST_SAT;
			end
			ST_SAT: begin
				cmd.do_sat = 1'b1;
				state_nxt  = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.step_led = leds_ready;
				if (leds_ready && sts.led_last) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nxt;
	end

	assign amp_ready  = (state_q == ST_IDLE);
	assign leds_valid = (state_q == ST_EMIT);

endmodule

`default_nettype wire

/* hdl/led_vu_dp.sv */
// ----------------------------------------------------------------------------
// led_vu_dp
// Datapath: config registers, log2/dB conversion, trackers, LED mapping and
// the per-LED record.
// ----------------------------------------------------------------------------
`default_nettype none

module led_vu_dp #(
	parameter int LED_COUNT       = led_vu_pkg::LED_COUNT_DEF,
	parameter int FULL_BRIGHTNESS = led_vu_pkg::FULL_BRIGHTNESS_DEF,
	parameter int DIM_BRIGHTNESS  = led_vu_pkg::DIM_BRIGHTNESS_DEF,
	parameter int FLIP_ORDER      = led_vu_pkg::FLIP_ORDER_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [led_vu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [led_vu_pkg::CFG_W-1:0]          cfg_data,
	input  wire led_vu_pkg::led_vu_cmd_t               cmd,
	input  wire logic [led_vu_pkg::AMP_W-1:0]          amplitude,
	output led_vu_pkg::led_vu_sts_t                    sts,
	output logic [led_vu_pkg::LED_W-1:0]               led_position,
	output logic [led_vu_pkg::HUE_W-1:0]               hue,
	output logic [led_vu_pkg::BRI_W-1:0]               brightness,
	output logic signed [led_vu_pkg::IDX_W-1:0]        level_led,
	output logic signed [led_vu_pkg::IDX_W-1:0]        peak_led,
	output logic                                       last_led
);
	import led_vu_pkg::*;

	localparam logic [LED_W-1:0] LAST_IDX = LED_W'(LED_COUNT - 1);
	localparam logic [BRI_W-1:0] BRI_FULL = BRI_W'(FULL_BRIGHTNESS);
	localparam logic [BRI_W-1:0] BRI_QTR  = BRI_W'(FULL_BRIGHTNESS / 4);
	localparam logic [BRI_W-1:0] BRI_DIM  = BRI_W'(DIM_BRIGHTNESS);

	// configuration
	logic [15:0]        min_db_q;
	logic [15:0]        leds_per_db_q;
	logic [ZONE_W-1:0]  orange_q;
	logic [ZONE_W-1:0]  red_q;
	logic [COEF_W-1:0]  level_rise_q;
	logic [COEF_W-1:0]  level_fall_q;
	logic [COEF_W-1:0]  peak_rise_q;
	logic [COEF_W-1:0]  peak_fall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_db_q      <= RST_MIN_DB;
			leds_per_db_q <= RST_LEDS_PER_DB;
			orange_q      <= RST_ORANGE_INDEX;
			red_q         <= RST_RED_INDEX;
			level_rise_q  <= RST_LEVEL_RISE;
			level_fall_q  <= RST_LEVEL_FALL;
			peak_rise_q   <= RST_PEAK_RISE;
			peak_fall_q   <= RST_PEAK_FALL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_DB:       min_db_q      <= cfg_data[15:0];
				REG_LEDS_PER_DB:  leds_per_db_q <= cfg_data[15:0];
				REG_ORANGE_INDEX: orange_q      <= cfg_data[ZONE_W-1:0];
				REG_RED_INDEX:    red_q         <= cfg_data[ZONE_W-1:0];
				REG_LEVEL_RISE:   level_rise_q  <= cfg_data;
				REG_LEVEL_FALL:   level_fall_q  <= cfg_data;
				REG_PEAK_RISE:    peak_rise_q   <= cfg_data;
				REG_PEAK_FALL:    peak_fall_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- log2 ----------------
	logic [AMP_W-1:0] amp_q;
	logic [AMP_W-1:0] amp_nz;
	logic [3:0]       lead;
	logic [AMP_W-1:0] norm;
	logic [3:0]       exp_q;
	logic [3:0]       seg_q;
	logic [10:0]      rem_q;

	always_ff @(posedge clk) begin
		if (cmd.load_amp) amp_q <= amplitude;
	end

	// zero amplitude reads as one
	assign amp_nz = (amp_q == '0) ? AMP_W'(1) : amp_q;

	always_comb begin
		lead = 4'd0;
		for (int i = 1; i < AMP_W; i++) begin
			if (amp_nz[i]) lead = 4'(i);
		end
	end

	assign norm = amp_nz << (4'd15 - lead);

	always_ff @(posedge clk) begin
		if (cmd.do_log) begin
			exp_q <= lead;
			seg_q <= norm[14:11];
			rem_q <= norm[10:0];
		end
	end

	logic [16:0]   tab_lo;
	logic [16:0]   tab_hi;
	logic [12:0]   tab_step;
	logic [23:0]   lerp_prod;
	logic [LG_W-1:0] lg_q;

	assign tab_lo    = log_frac({1'b0, seg_q});
	assign tab_hi    = log_frac(5'({1'b0, seg_q}) + 5'd1);
	assign tab_step  = 13'(tab_hi - tab_lo);
	assign lerp_prod = 24'(tab_step) * 24'(rem_q);

	always_ff @(posedge clk) begin
		if (cmd.do_lerp) begin
			lg_q <= {exp_q, 16'd0} + LG_W'(tab_lo) + LG_W'(lerp_prod[23:11]);
		end
	end

	// ---------------- dB ----------------
	logic [38:0]     db_prod;
	logic [38:0]     db_rnd;
	logic [DB_W-1:0] db_q;

	assign db_prod = 39'(lg_q) * 39'(DB_SLOPE);
	assign db_rnd  = db_prod + 39'd32768;

	always_ff @(posedge clk) begin
		if (cmd.do_db) db_q <= DB_OFFSET + db_rnd[39-1:16];
	end

	// ---------------- trackers ----------------
	logic [DB_W-1:0]   level_q;
	logic [DB_W-1:0]   peak_q;
	logic              lvl_up;
	logic              pk_up;
	logic [COEF_W-1:0] lvl_coef;
	logic [COEF_W-1:0] pk_coef;
	logic [DB_W-1:0]   lvl_diff;
	logic [DB_W-1:0]   pk_diff;
	logic [40:0]       lvl_prod_q;
	logic [40:0]       pk_prod_q;
	logic              lvl_up_q;
	logic              pk_up_q;

	assign lvl_up   = (db_q > level_q);
	assign pk_up    = (db_q > peak_q);
	assign lvl_coef = lvl_up ? ((level_rise_q > COEF_ONE) ? COEF_ONE : level_rise_q)
	                         : ((level_fall_q > COEF_ONE) ? COEF_ONE : level_fall_q);
	assign pk_coef  = pk_up ? ((peak_rise_q > COEF_ONE) ? COEF_ONE : peak_rise_q)
	                        : ((peak_fall_q > COEF_ONE) ? COEF_ONE : peak_fall_q);
	assign lvl_diff = lvl_up ? (db_q - level_q) : (level_q - db_q);
	assign pk_diff  = pk_up ? (db_q - peak_q) : (peak_q - db_q);

	always_ff @(posedge clk) begin
		if (cmd.do_trk) begin
			lvl_prod_q <= 41'(lvl_diff) * 41'(lvl_coef);
			pk_prod_q  <= 41'(pk_diff) * 41'(pk_coef);
			lvl_up_q   <= lvl_up;
			pk_up_q    <= pk_up;
		end
	end

	// step is truncated toward the old state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			peak_q  <= '0;
		end else if (cmd.do_upd) begin
			level_q <= lvl_up_q ? level_q + lvl_prod_q[39:16] : level_q - lvl_prod_q[39:16];
			peak_q  <= pk_up_q ? peak_q + pk_prod_q[39:16] : peak_q - pk_prod_q[39:16];
		end
	end

	// ---------------- LED mapping ----------------
	logic [DB_W-1:0] base;
	logic            lvl_ge;
	logic            pk_ge;
	logic [DB_W-1:0] lvl_off;
	logic [DB_W-1:0] pk_off;
	logic [39:0]     lvl_q40_q;
	logic [39:0]     pk_q40_q;
	logic            lvl_ge_q;
	logic            pk_ge_q;

	assign base    = {min_db_q, 8'd0};
	assign lvl_ge  = (level_q >= base);
	assign pk_ge   = (peak_q >= base);
	assign lvl_off = lvl_ge ? (level_q - base) : (base - level_q);
	assign pk_off  = pk_ge ? (peak_q - base) : (base - peak_q);

	always_ff @(posedge clk) begin
		if (cmd.do_map) begin
			lvl_q40_q <= 40'(lvl_off) * 40'(leds_per_db_q);
			pk_q40_q  <= 40'(pk_off) * 40'(leds_per_db_q);
			lvl_ge_q  <= lvl_ge;
			pk_ge_q   <= pk_ge;
		end
	end

	logic [15:0]              lvl_whole;
	logic [15:0]              pk_whole;
	logic signed [IDX_W-1:0]  lvl_idx;
	logic signed [IDX_W-1:0]  pk_idx;
	logic signed [IDX_W-1:0]  lvl_led_q;
	logic signed [IDX_W-1:0]  pk_led_q;

	assign lvl_whole = lvl_q40_q[39:24];
	assign pk_whole  = pk_q40_q[39:24];

	// below the base any nonzero step reads as one LED under the bar
	assign lvl_idx = lvl_ge_q ? ((lvl_whole > 16'd64) ? LED_IDX_MAX : IDX_W'(lvl_whole))
	                          : ((lvl_whole != '0) ? LED_IDX_NEG : LED_IDX_ZERO);
	assign pk_idx  = pk_ge_q ? ((pk_whole > 16'd64) ? LED_IDX_MAX : IDX_W'(pk_whole))
	                         : ((pk_whole != '0) ? LED_IDX_NEG : LED_IDX_ZERO);

	always_ff @(posedge clk) begin
		if (cmd.do_sat) begin
			lvl_led_q <= lvl_idx;
			pk_led_q  <= (pk_idx < lvl_idx) ? lvl_idx : pk_idx;
		end
	end

	// ---------------- LED walk ----------------
	logic [LED_W-1:0]        led_q;
	logic signed [IDX_W-1:0] led_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           led_q <= '0;
		else if (cmd.do_sat)   led_q <= '0;
		else if (cmd.step_led) led_q <= led_q + LED_W'(1);
	end

	assign led_s        = IDX_W'({2'b00, led_q});
	assign sts.led_last = (led_q == LAST_IDX);

	always_comb begin
		if ({1'b0, led_q} >= red_q)         hue = HUE_RED;
		else if ({1'b0, led_q} >= orange_q) hue = HUE_ORANGE;
		else                                hue = HUE_GREEN;

		if (led_s == pk_led_q)      brightness = BRI_FULL;
		else if (led_s <= lvl_led_q) brightness = BRI_QTR;
		else                        brightness = BRI_DIM;
	end

	assign led_position = (FLIP_ORDER != 0) ? LAST_IDX - led_q : led_q;
	assign level_led    = lvl_led_q;
	assign peak_led     = pk_led_q;
	assign last_led     = sts.led_last;

endmodule

`default_nettype wire

/* hdl/led_vu_meter_peak_hold.sv */
// ----------------------------------------------------------------------------
// led_vu_meter_peak_hold
// LED bar VU meter: amplitude to dB, level and peak trackers, LED records.
// ----------------------------------------------------------------------------
// Usage:
//   amp    - one peak-to-peak amplitude per transfer (zero counts as one).
//   leds   - LED_COUNT records per amplitude, bottom LED first, last_led set
//            on the final record; level_led/peak_led repeat in each record.
//   cfg_*  - register writes, taken only while no frame is in flight; the
//            user must keep to this, the block itself does not enforce it.
// Timing: after the amplitude transfer the sequencer walks the datapath steps
//   in order (leading-one/normalize, table interpolation, dB multiply, tracker
//   multiply, tracker update, LED-index multiply, saturate), and the first
//   record is valid once saturate is done. Records then leave one per cycle
//   while leds.ready is high.
// amp.ready is high only while no frame is pending. A stall on leds holds the
//   current record unchanged and the frame resumes where it stopped.
// Reset clears the trackers to zero and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module led_vu_meter_peak_hold #(
	parameter int LED_COUNT       = led_vu_pkg::LED_COUNT_DEF,
	parameter int FULL_BRIGHTNESS = led_vu_pkg::FULL_BRIGHTNESS_DEF,
	parameter int DIM_BRIGHTNESS  = led_vu_pkg::DIM_BRIGHTNESS_DEF,
	parameter int FLIP_ORDER      = led_vu_pkg::FLIP_ORDER_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	led_vu_amp_if.sink                             amp,
	led_vu_led_if.source                           leds,
	input  wire logic                              cfg_we,
	input  wire logic [led_vu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [led_vu_pkg::CFG_W-1:0]      cfg_data
);
	import led_vu_pkg::*;

	led_vu_cmd_t cmd;
	led_vu_sts_t sts;

	led_vu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.amp_valid  (amp.valid),
		.amp_ready  (amp.ready),
		.leds_valid (leds.valid),
		.leds_ready (leds.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	led_vu_dp #(
		.LED_COUNT       (LED_COUNT),
		.FULL_BRIGHTNESS (FULL_BRIGHTNESS),
		.DIM_BRIGHTNESS  (DIM_BRIGHTNESS),
		.FLIP_ORDER      (FLIP_ORDER)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.amplitude    (amp.amplitude),
		.sts          (sts),
		.led_position (leds.led_position),
		.hue          (leds.hue),
		.brightness   (leds.brightness),
		.level_led    (leds.level_led),
		.peak_led     (leds.peak_led),
		.last_led     (leds.last_led)
	);

endmodule

`default_nettype wire

/* hdl/led_vu_chk.sv */
// ----------------------------------------------------------------------------
// led_vu_chk
// Port-level checks of the VU meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module led_vu_chk (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                amp_valid,
	input wire logic                                amp_ready,
	input wire logic                                leds_valid,
	input wire logic                                leds_ready,
	input wire logic [led_vu_pkg::LED_W-1:0]        led_position,
	input wire logic signed [led_vu_pkg::IDX_W-1:0] level_led,
	input wire logic signed [led_vu_pkg::IDX_W-1:0] peak_led,
	input wire logic                                last_led
);
	import led_vu_pkg::*;

	// peak marker never sits under the level bar
	a_peak_over_level: assert property (@(posedge clk) disable iff (!arst_n)
		leds_valid |-> (peak_led >= level_led))
		else $error("peak_led below level_led");

	// no new amplitude while a frame is still being sent
	a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		leds_valid |-> !amp_ready)
		else $error("amplitude accepted during frame");

	// tracker indices are fixed across a frame
	a_frame_indices_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(leds_valid && leds_ready && !last_led) |=>
		(leds_valid && $stable(level_led) && $stable(peak_led)))
		else $error("frame ended early or indices changed");

	// frame closes after the last record
	a_frame_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(leds_valid && leds_ready && last_led) |=> !leds_valid)
		else $error("records continue after last_led");

	// stalled record holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(leds_valid && !leds_ready) |=> (leds_valid && $stable(led_position)))
		else $error("stalled record changed");

endmodule

bind led_vu_meter_peak_hold led_vu_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.amp_valid    (amp.valid),
	.amp_ready    (amp.ready),
	.leds_valid   (leds.valid),
	.leds_ready   (leds.ready),
	.led_position (leds.led_position),
	.level_led    (leds.level_led),
	.peak_led     (leds.peak_led),
	.last_led     (leds.last_led)
);

`default_nettype wire
